// ===== rtl/core/irpdd_pkg.sv =====
package irpdd_pkg;

  localparam int FRAME_BITS = 16;
  localparam int DUR_W      = 16;
  localparam int POS_W      = 6;
  localparam int SHIFT_W    = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [POS_W-1:0] FRAME_END = POS_W'((2 * FRAME_BITS) % (2 ** POS_W));
  localparam logic [POS_W:0]   FRAME_LEN = (POS_W + 1)'(2 * FRAME_BITS);

  localparam logic [DUR_W-1:0] ZERO_GAP_RST  = DUR_W'(390);
  localparam logic [DUR_W-1:0] ONE_GAP_RST   = DUR_W'(780);
  localparam logic [DUR_W-1:0] ACTIVE_RST    = DUR_W'(390);
  localparam logic [DUR_W-1:0] TOLERANCE_RST = DUR_W'(100);

  typedef enum logic [1:0] {
    REG_ZERO_GAP  = 2'd0,
    REG_ONE_GAP   = 2'd1,
    REG_ACTIVE    = 2'd2,
    REG_TOLERANCE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] zero_gap_us;
    logic [DUR_W-1:0] one_gap_us;
    logic [DUR_W-1:0] active_us;
    logic [DUR_W-1:0] tolerance_us;
  } cfg_t;

  typedef struct packed {
    logic             s1_valid;
    logic             in_frame;
    logic [POS_W-1:0] position;
  } frame_st_t;

  function automatic logic near_nominal(input logic [DUR_W-1:0] d,
                                        input logic [DUR_W-1:0] nominal,
                                        input logic [DUR_W-1:0] tol);
    logic [DUR_W-1:0] diff;
    diff = (d >= nominal) ? (d - nominal) : (nominal - d);
    return diff <= tol;
  endfunction

endpackage

// ===== rtl/core/irpdd_if.sv =====
interface ir_dur_if;
  logic                       valid;
  logic                       ready;
  logic [irpdd_pkg::DUR_W-1:0] duration_us;
  logic                       frame_start;

  modport source (output valid, duration_us, frame_start, input ready);
  modport sink   (input valid, duration_us, frame_start, output ready);
endinterface

interface ir_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [1:0] reserved_bits;
  logic [1:0] team_id;
  logic [3:0] player_num;
  logic [3:0] special_bits;
  logic [3:0] damage_value;

  modport source (output valid, status, reserved_bits, team_id, player_num,
                  special_bits, damage_value, input ready);
  modport sink   (input valid, status, reserved_bits, team_id, player_num,
                  special_bits, damage_value, output ready);
endinterface

// ===== rtl/core/irpdd_regs.sv =====
module irpdd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpdd_pkg::ADDR_W-1:0]  paddr,
  input  logic [irpdd_pkg::DATA_W-1:0]  pwdata,
  output logic [irpdd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output irpdd_pkg::cfg_t               cfg
);

  irpdd_pkg::reg_idx_t idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = irpdd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_gap_us  <= irpdd_pkg::ZERO_GAP_RST;
      cfg.one_gap_us   <= irpdd_pkg::ONE_GAP_RST;
      cfg.active_us    <= irpdd_pkg::ACTIVE_RST;
      cfg.tolerance_us <= irpdd_pkg::TOLERANCE_RST;
    end else if (wr) begin
      case (idx)
        irpdd_pkg::REG_ZERO_GAP:  cfg.zero_gap_us  <= pwdata[irpdd_pkg::DUR_W-1:0];
        irpdd_pkg::REG_ONE_GAP:   cfg.one_gap_us   <= pwdata[irpdd_pkg::DUR_W-1:0];
        irpdd_pkg::REG_ACTIVE:    cfg.active_us    <= pwdata[irpdd_pkg::DUR_W-1:0];
        irpdd_pkg::REG_TOLERANCE: cfg.tolerance_us <= pwdata[irpdd_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      irpdd_pkg::REG_ZERO_GAP:  prdata = irpdd_pkg::DATA_W'(cfg.zero_gap_us);
      irpdd_pkg::REG_ONE_GAP:   prdata = irpdd_pkg::DATA_W'(cfg.one_gap_us);
      irpdd_pkg::REG_ACTIVE:    prdata = irpdd_pkg::DATA_W'(cfg.active_us);
      irpdd_pkg::REG_TOLERANCE: prdata = irpdd_pkg::DATA_W'(cfg.tolerance_us);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/irpdd_frame.sv =====
module irpdd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  irpdd_pkg::cfg_t       cfg,
  ir_dur_if.sink                pulse,
  ir_res_if.source              res,
  output irpdd_pkg::frame_st_t  st
);

  logic                              s1_valid;
  logic [irpdd_pkg::DUR_W-1:0]       s1_dur;
  logic                              s1_start;

  logic                              in_frame;
  logic [irpdd_pkg::POS_W-1:0]       position;
  logic [irpdd_pkg::SHIFT_W-1:0]     bit_shift;
  logic                              pending_bit;
  logic                              error_seen;

  logic                              in_frame_next;
  logic [irpdd_pkg::POS_W-1:0]       position_next;
  logic [irpdd_pkg::SHIFT_W-1:0]     bit_shift_next;
  logic                              pending_bit_next;
  logic                              error_seen_next;

  logic                              advance;
  logic                              fire;
  logic                              emit;
  logic                              near_zero;
  logic                              near_one;
  logic                              near_active;
  logic [irpdd_pkg::POS_W-1:0]       position_inc;
  logic [irpdd_pkg::SHIFT_W-1:0]     value;

  assign advance     = !res.valid || res.ready;
  assign fire        = s1_valid && advance;
  assign pulse.ready = !s1_valid || advance;

  assign near_zero   = irpdd_pkg::near_nominal(s1_dur, cfg.zero_gap_us, cfg.tolerance_us);
  assign near_one    = irpdd_pkg::near_nominal(s1_dur, cfg.one_gap_us, cfg.tolerance_us);
  assign near_active = irpdd_pkg::near_nominal(s1_dur, cfg.active_us, cfg.tolerance_us);
  assign position_inc = position + irpdd_pkg::POS_W'(1);

  always_comb begin
    in_frame_next    = in_frame;
    position_next    = position;
    bit_shift_next   = bit_shift;
    pending_bit_next = pending_bit;
    error_seen_next  = error_seen;
    emit             = 1'b0;
    if (s1_start) begin
      in_frame_next    = 1'b1;
      position_next    = '0;
      bit_shift_next   = '0;
      pending_bit_next = 1'b0;
      error_seen_next  = 1'b0;
    end else if (in_frame) begin
      if (!position[0]) begin
        pending_bit_next = !near_zero && near_one;
        if (!near_zero && !near_one) begin
          error_seen_next = 1'b1;
        end
      end else begin
        if (!near_active) begin
          error_seen_next = 1'b1;
        end
        bit_shift_next = {bit_shift[irpdd_pkg::SHIFT_W-2:0], pending_bit};
      end
      position_next = position_inc;
      if (position_inc == irpdd_pkg::FRAME_END) begin
        emit          = 1'b1;
        in_frame_next = 1'b0;
        position_next = '0;
      end
    end
  end

  assign value = error_seen_next ? '0 : bit_shift_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pulse.ready) begin
      s1_valid <= pulse.valid;
    end
    if (pulse.valid && pulse.ready) begin
      s1_dur   <= pulse.duration_us;
      s1_start <= pulse.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      position    <= '0;
      bit_shift   <= '0;
      pending_bit <= 1'b0;
      error_seen  <= 1'b0;
    end else if (fire) begin
      in_frame    <= in_frame_next;
      position    <= position_next;
      bit_shift   <= bit_shift_next;
      pending_bit <= pending_bit_next;
      error_seen  <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= fire && emit;
    end
    if (fire && emit) begin
      res.status        <= error_seen_next;
      res.reserved_bits <= value[15:14];
      res.team_id       <= value[13:12];
      res.player_num    <= value[11:8];
      res.special_bits  <= value[7:4];
      res.damage_value  <= value[3:0];
    end
  end

  assign st.s1_valid = s1_valid;
  assign st.in_frame = in_frame;
  assign st.position = position;

endmodule

// ===== rtl/core/ir_pulse_distance_decoder.sv =====
// Channel   Role    Transaction
// pulse     sink    one measured duration_us with its frame_start flag
// frame     source  one decoded frame: status plus the five bit fields
// APB       slave   write/read of zero_gap_us, one_gap_us, active_us, tolerance_us
//
// One pulse per cycle sustained while no frame result is stalled; a pulse passes through
// the input register, the decode step and then the result register.
// A frame result appears after the 32nd duration following a start pulse.
// rst is synchronous, active high; it clears control state and loads register defaults.
// A stalled frame result holds; at most one further pulse enters the input register meanwhile.
module ir_pulse_distance_decoder (
  input  logic                          clk,
  input  logic                          rst,
  ir_dur_if.sink                        pulse,
  ir_res_if.source                      frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpdd_pkg::ADDR_W-1:0]  paddr,
  input  logic [irpdd_pkg::DATA_W-1:0]  pwdata,
  output logic [irpdd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  irpdd_pkg::cfg_t      cfg;
  irpdd_pkg::frame_st_t st;

  irpdd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irpdd_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pulse (pulse),
    .res   (frame),
    .st    (st)
  );

`ifndef SYNTH
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !st.in_frame |-> st.position == '0)
    else $error("position nonzero outside a frame");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    st.in_frame |-> {1'b0, st.position} < irpdd_pkg::FRAME_LEN)
    else $error("position past frame length");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.status |-> frame.reserved_bits == '0 && frame.team_id == '0 &&
      frame.player_num == '0 && frame.special_bits == '0 && frame.damage_value == '0)
    else $error("invalid frame carries nonzero fields");

  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(frame.valid) |-> $past(st.in_frame) && $past(st.s1_valid))
    else $error("result produced without an open frame");
`endif

endmodule

// ===== verif/ir_pulse_distance_decoder_test.sv =====
module ir_pulse_distance_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irpdd_pkg::*;

  localparam int FRAME_DUR   = 2 * FRAME_BITS;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic       status;
    logic [1:0] reserved_bits;
    logic [1:0] team_id;
    logic [3:0] player_num;
    logic [3:0] special_bits;
    logic [3:0] damage_value;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ir_dur_if pulse_if ();
  ir_res_if frame_if ();

  ir_pulse_distance_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .pulse   (pulse_if),
    .frame   (frame_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk = ~clk;

  cfg_t        mdl_cfg  = '{ZERO_GAP_RST, ONE_GAP_RST, ACTIVE_RST, TOLERANCE_RST};
  logic [5:0]  mdl_pos  = '0;
  logic        mdl_open = 1'b0;
  logic [15:0] mdl_bits = '0;
  logic        mdl_pend = 1'b0;
  logic        mdl_bad  = 1'b0;

  frame_res_t frames_due[$];
  int n_mismatch    = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;

  function automatic void note_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("%s", msg);
  endfunction

  function automatic string fmt_frame(frame_res_t r);
    return $sformatf("status=%0d reserved=%0d team=%0d player=%0d special=%0d damage=%0d",
                     r.status, r.reserved_bits, r.team_id, r.player_num, r.special_bits,
                     r.damage_value);
  endfunction

  function automatic bit within_tol(logic [15:0] d, logic [15:0] nom);
    int delta;
    delta = int'(d) - int'(nom);
    if (delta < 0) delta = -delta;
    return delta <= int'(mdl_cfg.tolerance_us);
  endfunction

  function automatic void decode_step(logic [15:0] dur, logic start);
    frame_res_t res;
    logic [15:0] word;
    if (start) begin
      mdl_open = 1'b1;
      mdl_pos  = '0;
      mdl_bits = '0;
      mdl_pend = 1'b0;
      mdl_bad  = 1'b0;
      return;
    end
    if (!mdl_open) return;
    if (!mdl_pos[0]) begin
      if (within_tol(dur, mdl_cfg.zero_gap_us)) begin
        mdl_pend = 1'b0;
      end else if (within_tol(dur, mdl_cfg.one_gap_us)) begin
        mdl_pend = 1'b1;
      end else begin
        mdl_pend = 1'b0;
        mdl_bad  = 1'b1;
      end
    end else begin
      if (!within_tol(dur, mdl_cfg.active_us)) mdl_bad = 1'b1;
      mdl_bits = {mdl_bits[14:0], mdl_pend};
    end
    mdl_pos = mdl_pos + 6'd1;
    if (mdl_pos != 6'(FRAME_DUR)) return;
    mdl_open = 1'b0;
    mdl_pos  = '0;
    word = mdl_bad ? 16'h0000 : mdl_bits;
    res.status        = mdl_bad;
    res.reserved_bits = word[15:14];
    res.team_id       = word[13:12];
    res.player_num    = word[11:8];
    res.special_bits  = word[7:4];
    res.damage_value  = word[3:0];
    frames_due.push_back(res);
  endfunction

  function automatic logic [15:0] pick_near(logic [15:0] nom);
    int lo;
    int hi;
    lo = int'(nom) - int'(mdl_cfg.tolerance_us);
    hi = int'(nom) + int'(mdl_cfg.tolerance_us);
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 9))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] pick_off(logic [15:0] nom);
    int v;
    case ($urandom_range(0, 2))
      0: v = int'(nom) + int'(mdl_cfg.tolerance_us) + 1;
      1: v = int'(nom) - int'(mdl_cfg.tolerance_us) - 1;
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0 || v > 65535) v = int'($urandom_range(0, 65535));
    return 16'(v);
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    src_idle_pct  = (mode == IDLE_SRC) ? 88 : (mode == IDLE_BOTH) ? 20 : 0;
    snk_stall_pct = (mode == IDLE_SNK) ? 88 : (mode == IDLE_BOTH) ? 20 : 0;
  endfunction

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_res_t got;
    frame_res_t want;
    if (!rst && frame_if.valid && frame_if.ready) begin
      got = {frame_if.status, frame_if.reserved_bits, frame_if.team_id, frame_if.player_num,
             frame_if.special_bits, frame_if.damage_value};
      if (frames_due.size() == 0) begin
        note_mismatch({"unexpected frame result: ", fmt_frame(got)});
      end else begin
        want = frames_due.pop_front();
        if (got.status !== want.status || got.reserved_bits !== want.reserved_bits ||
            got.team_id !== want.team_id || got.player_num !== want.player_num ||
            got.special_bits !== want.special_bits ||
            got.damage_value !== want.damage_value) begin
          note_mismatch({"frame result mismatch: expected ", fmt_frame(want),
                         " got ", fmt_frame(got)});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pulse_if.valid && pulse_if.ready) || (frame_if.valid && frame_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("ir_pulse_distance_decoder_test NOT OK");
      $finish;
    end
  end

  task automatic send_pulse(logic [15:0] dur, logic start);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pulse_if.valid <= 1'b0;
      @(posedge clk);
    end
    pulse_if.valid       <= 1'b1;
    pulse_if.duration_us <= dur;
    pulse_if.frame_start <= start;
    do @(posedge clk); while (!pulse_if.ready);
    decode_step(dur, start);
  endtask

  task automatic send_frame(logic [15:0] word, int corrupt_pct, int n_dur);
    logic [15:0] nom;
    send_pulse(16'($urandom), 1'b1);
    for (int i = 0; i < n_dur; i++) begin
      if (i % 2 == 0) begin
        nom = word[15 - i / 2] ? mdl_cfg.one_gap_us : mdl_cfg.zero_gap_us;
      end else begin
        nom = mdl_cfg.active_us;
      end
      if ($urandom_range(0, 99) < corrupt_pct) begin
        send_pulse(pick_off(nom), 1'b0);
      end else begin
        send_pulse(pick_near(nom), 1'b0);
      end
    end
  endtask

  task automatic send_fixed_frame(logic [15:0] gap, logic [15:0] act);
    send_pulse(16'hFFFF, 1'b1);
    repeat (FRAME_BITS) begin
      send_pulse(gap, 1'b0);
      send_pulse(act, 1'b0);
    end
  endtask

  task automatic wait_drain();
    pulse_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_check(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_ZERO_GAP:  want = DATA_W'(mdl_cfg.zero_gap_us);
      REG_ONE_GAP:   want = DATA_W'(mdl_cfg.one_gap_us);
      REG_ACTIVE:    want = DATA_W'(mdl_cfg.active_us);
      REG_TOLERANCE: want = DATA_W'(mdl_cfg.tolerance_us);
      default:       want = '0;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      note_mismatch($sformatf("register %s readback: expected %0d got %0d",
                              idx.name(), want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ZERO_GAP:  mdl_cfg.zero_gap_us  = value;
      REG_ONE_GAP:   mdl_cfg.one_gap_us   = value;
      REG_ACTIVE:    mdl_cfg.active_us    = value;
      REG_TOLERANCE: mdl_cfg.tolerance_us = value;
      default: ;
    endcase
    apb_check(idx);
  endtask

  task automatic set_config(logic [15:0] zero_gap, logic [15:0] one_gap,
                            logic [15:0] active, logic [15:0] tol);
    wait_drain();
    apb_write(REG_ZERO_GAP, zero_gap);
    apb_write(REG_ONE_GAP, one_gap);
    apb_write(REG_ACTIVE, active);
    apb_write(REG_TOLERANCE, tol);
  endtask

  task automatic test_register_defaults();
    apb_check(REG_ZERO_GAP);
    apb_check(REG_ONE_GAP);
    apb_check(REG_ACTIVE);
    apb_check(REG_TOLERANCE);
  endtask

  task automatic test_directed_frames();
    set_idle(IDLE_NONE);
    send_pulse(16'h0000, 1'b0);
    send_pulse(16'hFFFF, 1'b0);
    send_frame(16'h0000, 0, FRAME_DUR);
    send_frame(16'hFFFF, 0, FRAME_DUR);
    send_frame(16'hA5C3, 0, FRAME_DUR);
    // restart mid-frame: drop the open frame
    send_frame(16'h1234, 0, 11);
    send_frame(16'h5A3C, 0, FRAME_DUR);
    send_frame(16'h0F0F, 100, FRAME_DUR);
    send_fixed_frame(16'h0000, mdl_cfg.active_us);
    send_fixed_frame(16'hFFFF, mdl_cfg.active_us);
    send_fixed_frame(mdl_cfg.zero_gap_us, 16'hFFFF);
    send_pulse(16'hFFFF, 1'b0);
    // gap inside both bands decodes as zero
    set_config(16'd400, 16'd500, ACTIVE_RST, TOLERANCE_RST);
    send_fixed_frame(16'd450, 16'd390);
    send_frame(16'hC3A5, 0, FRAME_DUR);
  endtask

  task automatic test_extreme_settings();
    set_config(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    set_idle(IDLE_BOTH);
    send_fixed_frame(16'hFFFF, 16'h0000);
    repeat (2) send_frame(16'($urandom), 5, FRAME_DUR);
    set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_fixed_frame(16'h0000, 16'h0000);
    send_frame(16'($urandom), 0, FRAME_DUR);
  endtask

  task automatic test_random_traffic();
    int pick;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 0) begin
        set_config(ZERO_GAP_RST, ONE_GAP_RST, ACTIVE_RST, TOLERANCE_RST);
      end else begin
        set_config(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 3000)));
      end
      set_idle(idle_mode_t'(ph));
      repeat (8) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          repeat ($urandom_range(1, 3)) send_pulse(16'($urandom), 1'b0);
        end else if (pick < 14) begin
          send_frame(16'($urandom), 10, $urandom_range(1, FRAME_DUR - 1));
        end else begin
          send_frame(16'($urandom), ($urandom_range(0, 4) == 0) ? 10 : 0, FRAME_DUR);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    set_idle(IDLE_NONE);
    hold_reqs++;
    repeat (6) send_frame(16'($urandom), 0, FRAME_DUR);
    // pause the sender until the last frame result has arrived
    wait_drain();
  endtask

  initial begin
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    pulse_if.valid       <= 1'b0;
    pulse_if.duration_us <= '0;
    pulse_if.frame_start <= 1'b0;
    set_idle(IDLE_NONE);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_register_defaults();
    test_directed_frames();
    test_extreme_settings();
    test_random_traffic();
    test_backpressure();
    wait_drain();
    repeat (8) @(posedge clk);
    if (n_mismatch == 0 && frames_due.size() == 0) begin
      $display("ir_pulse_distance_decoder_test OK");
    end else begin
      $display("ir_pulse_distance_decoder_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== ir_pulse_distance_decoder.f =====
rtl/core/irpdd_pkg.sv
rtl/core/irpdd_if.sv
rtl/core/irpdd_regs.sv
rtl/core/irpdd_frame.sv
rtl/core/ir_pulse_distance_decoder.sv
verif/ir_pulse_distance_decoder_test.sv
